>>> rtl/pre_pkg.sv
package pre_pkg;

    localparam int COORD_W_DEF = 32;
    localparam int COUNT_W_DEF = 16;
    localparam int SUM_W       = 48;
    localparam int NUM_REGS    = 6;
    localparam int IDX_W       = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_R0L = 3'd0;
    localparam logic [IDX_W-1:0] REG_R0R = 3'd1;
    localparam logic [IDX_W-1:0] REG_R1L = 3'd2;
    localparam logic [IDX_W-1:0] REG_R1R = 3'd3;
    localparam logic [IDX_W-1:0] REG_R2L = 3'd4;
    localparam logic [IDX_W-1:0] REG_R2R = 3'd5;

    // item passed from front to back
    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic signed [31:0] observed_x;
        logic signed [31:0] observed_y;
        logic               has_observed;
        logic               last_point;
    } pre_item_t;

endpackage

>>> rtl/pre_front.sv
// Input side: config registers and a two-entry item queue.
module pre_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [pre_pkg::IDX_W-1:0] cfg_index,
    input  logic [63:0]               cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  pre_pkg::pre_item_t        in_item,
    output logic                      q_valid,
    input  logic                      q_ready,
    output pre_pkg::pre_item_t        q_item,
    output logic [63:0]               regs_out [pre_pkg::NUM_REGS]
);
    import pre_pkg::*;

    logic [63:0] regs_reg [NUM_REGS];
    pre_item_t   buf_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;

    assign cfg_ready = 1'b1;
    assign regs_out  = regs_reg;
    assign in_ready  = cnt_reg != 2'd2;
    assign q_valid   = cnt_reg != 2'd0;
    assign q_item    = buf_reg[rp_reg];

    // config writes, unknown index ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) regs_reg[i] <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_R0L: regs_reg[0] <= cfg_data;
                REG_R0R: regs_reg[1] <= cfg_data;
                REG_R1L: regs_reg[2] <= cfg_data;
                REG_R1R: regs_reg[3] <= cfg_data;
                REG_R2L: regs_reg[4] <= cfg_data;
                REG_R2R: regs_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // queue
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) buf_reg[wp_reg] <= in_item;
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (in_valid && in_ready) wp_reg <= ~wp_reg;
            if (q_valid && q_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'((in_valid && in_ready) ? 1 : 0)
                               - 2'((q_valid && q_ready) ? 1 : 0);
        end
    end
endmodule

>>> rtl/pre_back.sv
// Execution side: sequencer over shared multiplier, divider and square root.
module pre_back #(
    parameter int COORD_WIDTH = pre_pkg::COORD_W_DEF,
    parameter int COUNT_WIDTH = pre_pkg::COUNT_W_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  pre_pkg::pre_item_t       q_item,
    input  logic [63:0]              regs_in [pre_pkg::NUM_REGS],
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [COORD_WIDTH-1:0]   o_px,
    output logic [COORD_WIDTH-1:0]   o_py,
    output logic [COORD_WIDTH-1:0]   o_err,
    output logic                     o_ev,
    output logic                     o_fault,
    output logic [COORD_WIDTH-1:0]   o_max,
    output logic [COORD_WIDTH-1:0]   o_mean,
    output logic                     o_done
);
    import pre_pkg::*;

    localparam int DIVW = 64;
    localparam int DCW  = 7;
    // pixel difference magnitude: saturated projection minus a 32-bit observation
    localparam int DW   = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 1;
    localparam logic [63:0] LIM  = 64'(1) << (COORD_WIDTH - 1);
    localparam logic [63:0] UMAX = (64'(1) << COORD_WIDTH) - 64'(1);
    localparam logic [SUM_W-1:0] SUMMAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNTMAX = '1;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MUL  = 10'b0000000010,
        S_DIVS = 10'b0000000100,
        S_DIV  = 10'b0000001000,
        S_SQS  = 10'b0000010000,
        S_ERR  = 10'b0000100000,
        S_SQ   = 10'b0001000000,
        S_MNS  = 10'b0010000000,
        S_MN   = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } state_t;

    state_t            st_reg;
    pre_item_t         it_reg;
    logic [3:0]        k_reg;
    logic signed [49:0] acc_reg [3];
    logic              sel_reg;
    logic signed [63:0] pxs_reg, pys_reg;
    // shared divider
    logic [DIVW-1:0]   dn_reg, dq_reg;
    logic [DIVW:0]     dr_reg;
    logic [DIVW-1:0]   dd_reg;
    logic [DCW-1:0]    dc_reg;
    logic              dneg_reg;
    // sqrt (restoring, digit by digit on 128-bit radicand)
    logic [127:0]      sqs_reg;
    logic [63:0]       sqr_reg;
    logic [129:0]      sqrem_reg;
    logic [DCW-1:0]    sqc_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [31:0]       lg_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic              fault_reg, ev_reg;
    logic [COORD_WIDTH-1:0] err_reg, max_reg, mean_reg;

    assign q_ready = st_reg == S_IDLE;
    assign m_valid = st_reg == S_OUT;
    assign o_px = pxs_reg[COORD_WIDTH-1:0];
    assign o_py = pys_reg[COORD_WIDTH-1:0];
    assign o_err = err_reg;
    assign o_ev = ev_reg;
    assign o_fault = fault_reg;
    assign o_max = max_reg;
    assign o_mean = mean_reg;
    assign o_done = it_reg.last_point;

    // one product a cycle: k = row*4 + col
    logic [1:0] row_c, col_c;
    logic [63:0] rg;
    logic signed [31:0] ent, crd;
    logic signed [63:0] prod;
    logic signed [49:0] addend;
    always_comb begin
        row_c = k_reg[3:2];
        col_c = k_reg[1:0];
        rg = regs_in[{1'b0, row_c} * 3'd2 + {2'b0, col_c[1]}];
        ent = col_c[0] ? $signed(rg[31:0]) : $signed(rg[63:32]);
        case (col_c)
            2'd0: crd = it_reg.world_x;
            2'd1: crd = it_reg.world_y;
            default: crd = it_reg.world_z;
        endcase
        prod = ent * crd;
        addend = (col_c == 2'd3) ? 50'(ent) : 50'(prod >>> 16);
    end

    // divider operands
    logic signed [49:0] num_c, w_c;
    logic [63:0] num_mag, den_mag;
    always_comb begin
        num_c = sel_reg ? acc_reg[1] : acc_reg[0];
        w_c = acc_reg[2];
        num_mag = 64'(num_c < 0 ? -num_c : num_c) << 16;
        den_mag = 64'(w_c < 0 ? -w_c : w_c);
    end

    // restoring division step
    logic [DIVW:0] dtr;
    logic [DIVW:0] dsub;
    always_comb begin
        dtr = {dr_reg[DIVW-1:0], dn_reg[DIVW-1]};
        dsub = dtr - {1'b0, dd_reg};
    end

    // signed saturation of quotient
    logic signed [63:0] dsat;
    always_comb begin
        if (dneg_reg) dsat = (dq_reg >= LIM) ? -$signed(LIM) : -$signed(dq_reg);
        else          dsat = (dq_reg >= LIM) ? $signed(LIM - 64'(1)) : $signed(dq_reg);
    end

    // error operands
    logic signed [64:0] dx, dy;
    logic [DW-1:0] adx, ady;
    logic [2*DW-1:0] sqx, sqy;
    logic [127:0] ssum;
    always_comb begin
        dx = 65'(pxs_reg) - 65'(it_reg.observed_x);
        dy = 65'(pys_reg) - 65'(it_reg.observed_y);
        adx = DW'(dx < 0 ? -dx : dx);
        ady = DW'(dy < 0 ? -dy : dy);
        sqx = adx * adx;
        sqy = ady * ady;
        ssum = 128'(sqx) + 128'(sqy);
    end

    // sqrt step: two radicand bits per cycle
    logic [129:0] sqt, sqtry;
    always_comb begin
        sqt = {sqrem_reg[127:0], sqs_reg[127:126]};
        sqtry = sqt - {64'b0, sqr_reg, 2'b01};
    end

    logic [63:0] errv;
    logic [SUM_W:0] sadd;
    always_comb begin
        errv = (sqr_reg > UMAX) ? UMAX : sqr_reg;
        sadd = {1'b0, sum_reg} + (SUM_W+1)'(errv);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            sum_reg <= '0; lg_reg <= '0; cnt_reg <= '0;
        end else begin
            unique case (st_reg)
                S_IDLE: if (q_valid) begin
                    it_reg <= q_item;
                    k_reg <= '0;
                    for (int i = 0; i < 3; i++) acc_reg[i] <= '0;
                    st_reg <= S_MUL;
                end
                S_MUL: begin
                    acc_reg[row_c] <= acc_reg[row_c] + addend;
                    k_reg <= k_reg + 4'd1;
                    if (k_reg == 4'd11) begin
                        sel_reg <= 1'b0;
                        st_reg <= S_DIVS;
                    end
                end
                S_DIVS: begin
                    if (sel_reg) begin
                        // x quotient is final, start on y
                        pxs_reg <= dsat;
                        dn_reg <= num_mag; dd_reg <= den_mag;
                        dr_reg <= '0; dq_reg <= '0; dc_reg <= '0;
                        dneg_reg <= (num_c < 0) != (w_c < 0);
                        st_reg <= S_DIV;
                    end else if (w_c == 0) begin
                        fault_reg <= 1'b1;
                        ev_reg <= 1'b0; err_reg <= '0;
                        pxs_reg <= '0; pys_reg <= '0;
                        if (cnt_reg != CNTMAX) cnt_reg <= cnt_reg + 1'b1;
                        st_reg <= S_MNS;
                    end else begin
                        fault_reg <= 1'b0;
                        ev_reg <= 1'b0; err_reg <= '0;
                        dn_reg <= num_mag; dd_reg <= den_mag;
                        dr_reg <= '0; dq_reg <= '0; dc_reg <= '0;
                        dneg_reg <= (num_c < 0) != (w_c < 0);
                        st_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!dsub[DIVW]) begin
                        dr_reg <= dsub; dq_reg <= {dq_reg[DIVW-2:0], 1'b1};
                    end else begin
                        dr_reg <= dtr; dq_reg <= {dq_reg[DIVW-2:0], 1'b0};
                    end
                    dn_reg <= {dn_reg[DIVW-2:0], 1'b0};
                    dc_reg <= dc_reg + 1'b1;
                    if (dc_reg == DCW'(DIVW-1)) begin
                        if (sel_reg) begin
                            st_reg <= S_SQS;
                        end else begin
                            sel_reg <= 1'b1;
                            st_reg <= S_DIVS;
                        end
                    end
                end
                S_SQS: begin
                    // y quotient is final
                    pys_reg <= dsat;
                    st_reg <= S_ERR;
                end
                S_ERR: begin
                    if (it_reg.has_observed) begin
                        sqs_reg <= ssum; sqr_reg <= '0; sqrem_reg <= '0; sqc_reg <= '0;
                        st_reg <= S_SQ;
                    end else begin
                        if (cnt_reg != CNTMAX) cnt_reg <= cnt_reg + 1'b1;
                        st_reg <= S_MNS;
                    end
                end
                S_SQ: begin
                    sqs_reg <= {sqs_reg[125:0], 2'b00};
                    if (!sqtry[129]) begin
                        sqrem_reg <= sqtry; sqr_reg <= {sqr_reg[62:0], 1'b1};
                    end else begin
                        sqrem_reg <= sqt; sqr_reg <= {sqr_reg[62:0], 1'b0};
                    end
                    sqc_reg <= sqc_reg + 1'b1;
                    if (sqc_reg == DCW'(63)) st_reg <= S_MNS;
                end
                S_MNS: begin
                    if (it_reg.has_observed && !fault_reg && !ev_reg && sqc_reg == DCW'(64)) begin
                        // fold in the finished error
                        ev_reg <= 1'b1;
                        err_reg <= errv[COORD_WIDTH-1:0];
                        if (errv > 64'(lg_reg)) lg_reg <= errv > 64'hFFFFFFFF ? '1 : errv[31:0];
                        sum_reg <= sadd[SUM_W] ? SUMMAX : sadd[SUM_W-1:0];
                        if (cnt_reg != CNTMAX) cnt_reg <= cnt_reg + 1'b1;
                    end else if (it_reg.last_point) begin
                        dn_reg <= 64'(sum_reg); dd_reg <= 64'(cnt_reg);
                        dr_reg <= '0; dq_reg <= '0; dc_reg <= '0;
                        st_reg <= S_MN;
                    end else begin
                        max_reg <= '0; mean_reg <= '0;
                        st_reg <= S_OUT;
                    end
                end
                S_MN: begin
                    if (dc_reg == DCW'(DIVW)) begin
                        // mean quotient is final: publish stats and clear the set
                        max_reg <= (64'(lg_reg) > UMAX) ? UMAX[COORD_WIDTH-1:0]
                                                        : COORD_WIDTH'(lg_reg);
                        mean_reg <= (dq_reg > UMAX) ? UMAX[COORD_WIDTH-1:0]
                                                    : dq_reg[COORD_WIDTH-1:0];
                        sum_reg <= '0; lg_reg <= '0; cnt_reg <= '0;
                        st_reg <= S_OUT;
                    end else begin
                        if (!dsub[DIVW]) begin
                            dr_reg <= dsub; dq_reg <= {dq_reg[DIVW-2:0], 1'b1};
                        end else begin
                            dr_reg <= dtr; dq_reg <= {dq_reg[DIVW-2:0], 1'b0};
                        end
                        dn_reg <= {dn_reg[DIVW-2:0], 1'b0};
                        dc_reg <= dc_reg + 1'b1;
                    end
                end
                S_OUT: begin
                    if (m_ready) st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/pinhole_reprojection_error.sv
// Channel | Dir | Payload
// cfg     | in  | cfg_index (3), cfg_data (64)
// s_axis  | in  | tdata: world_x,world_y,world_z,observed_x,observed_y; tuser: has_observed; tlast
// m_axis  | out | tdata: projected_x,projected_y,point_error,max,mean; tuser: error_valid,depth_fault; tlast
// The back multiplies, divides for each coordinate and takes the square root before a result
// is offered; without an observation the square root is skipped, on zero depth the divides
// are skipped as well; the last item of a set adds the mean divide.
// Reset (aresetn low, synchronous) clears config registers, statistics accumulators and queue.
// A result holds the back until m_axis_tready; the two-item queue keeps taking input until full.
module pinhole_reprojection_error #(
    parameter int COORD_WIDTH = pre_pkg::COORD_W_DEF,
    parameter int COUNT_WIDTH = pre_pkg::COUNT_W_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [pre_pkg::IDX_W-1:0] cfg_index,
    input  logic [63:0]               cfg_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // world_x, world_y, world_z, observed_x, observed_y
    input  logic [159:0]              s_axis_tdata,
    // has_observed
    input  logic                      s_axis_tuser,
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // projected_x, projected_y, point_error, max_error_out, mean_error_out
    output logic [5*COORD_WIDTH-1:0]  m_axis_tdata,
    // error_valid, depth_fault
    output logic [1:0]                m_axis_tuser,
    output logic                      m_axis_tlast
);
    import pre_pkg::*;

    pre_item_t in_item, q_item;
    logic q_valid, q_ready;
    logic [63:0] regs [NUM_REGS];
    logic [COORD_WIDTH-1:0] px, py, er, mx, mn;
    logic ev, fl;

    assign in_item = '{world_x: s_axis_tdata[31:0], world_y: s_axis_tdata[63:32],
                       world_z: s_axis_tdata[95:64], observed_x: s_axis_tdata[127:96],
                       observed_y: s_axis_tdata[159:128], has_observed: s_axis_tuser,
                       last_point: s_axis_tlast};

    pre_front u_front (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item,
        .q_valid, .q_ready, .q_item, .regs_out(regs)
    );

    pre_back #(.COORD_WIDTH(COORD_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_item, .regs_in(regs),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .o_px(px), .o_py(py), .o_err(er), .o_ev(ev), .o_fault(fl),
        .o_max(mx), .o_mean(mn), .o_done(m_axis_tlast)
    );

    assign m_axis_tdata = {mn, mx, er, py, px};
    assign m_axis_tuser = {fl, ev};

    // checks
    a_fault_noerr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0]) else $error("fault with error");
    a_noerr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> er == '0) else $error("stray error");
    a_nolast_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> mx == '0 && mn == '0) else $error("stray stats");
endmodule
